// ----- rtl/fast_inverse_square_root_assert.svh -----
// Assertion macros used by the checker file.
`ifndef FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH
`define FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH
// Clocked assertion, idle while reset is held.
`define FISR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Assertion that is also checked while reset is held.
`define FISR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ----- rtl/fisr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_pkg
// Types, constants and single-precision arithmetic helpers.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] GuessBase = 32'h5F3504F3;
  localparam logic [31:0] FpHalf    = 32'h3F000000;
  localparam logic [31:0] FpThreeHalves = 32'h3FC00000;
  localparam logic [31:0] FpDefaultNan  = 32'hFFC00000;

  typedef struct packed {
    logic [31:0] h;    // half of the operand
    logic [31:0] y;    // current estimate
    logic        act;  // apply the next refinement
    logic        two;  // two refinements requested
  } item_t;

  // Single-precision multiply, round to nearest even.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p, pn;
    logic [5:0]         k;
    logic signed [10:0] e, nrs;
    logic [4:0]         rs;
    logic [79:0]        w;
    logic [23:0]        mant;
    logic [7:0]         field;
    logic               g, st, rnd;
    logic [30:0]        mag;
    logic [31:0]        r;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    k  = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) k = i[5:0];
    end
    pn  = p << (6'd47 - k);
    e   = 11'(ea) + 11'(eb) - 11'sd127 + 11'(k) - 11'sd46;
    nrs = 11'sd1 - e;
    rs  = (nrs > 11'sd26) ? 5'd26 : nrs[4:0];
    w   = {pn, 32'd0} >> ((e < 11'sd1) ? rs : 5'd0);
    mant  = w[79:56];
    g     = w[55];
    st    = |w[54:0];
    field = (e < 11'sd1) ? 8'd0 : e[7:0];
    rnd   = g & (st | mant[0]);
    mag   = {field, mant[22:0]} + 31'(rnd);
    r     = {s, mag};
    if (e > 11'sd254) r = {s, 8'hFF, 23'd0};
    if (ma == 24'd0 || mb == 24'd0) r = {s, 31'd0};
    if (a[30:23] == 8'hFF && a[22:0] == 23'd0) begin
      r = (b[30:0] == 31'd0) ? FpDefaultNan : {s, 8'hFF, 23'd0};
    end
    if (b[30:23] == 8'hFF && b[22:0] == 23'd0) begin
      r = (a[30:0] == 31'd0) ? FpDefaultNan : {s, 8'hFF, 23'd0};
    end
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) r = b | 32'h0040_0000;
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) r = a | 32'h0040_0000;
    return r;
  endfunction

  // Single-precision subtract a - b, round to nearest even.
  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    logic        sb, sx, sy;
    logic [31:0] bn, x, y;
    logic [7:0]  ex, ey, d;
    logic [23:0] mx, my;
    logic [26:0] ax, by;
    logic [58:0] bw;
    logic [27:0] sum;
    logic [4:0]  k, lz, sh;
    logic [8:0]  e;
    logic [26:0] nm;
    logic [7:0]  field;
    logic        g, st, rnd;
    logic [30:0] mag;
    logic [31:0] r;
    sb = ~b[31];
    bn = {sb, b[30:0]};
    if (a[30:0] < b[30:0]) begin
      x = bn;
      y = a;
    end else begin
      x = a;
      y = bn;
    end
    sx = x[31];
    sy = y[31];
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    d  = ex - ey;
    ax = {mx, 3'd0};
    bw = {my, 3'd0, 32'd0} >> ((d > 8'd31) ? 8'd31 : d);
    by = {bw[58:33], bw[32] | (|bw[31:0])};
    sum = (sx == sy) ? ({1'b0, ax} + {1'b0, by}) : ({1'b0, ax} - {1'b0, by});
    k = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) k = i[4:0];
    end
    lz = 5'd26 - k;
    e  = 9'd0;
    if (sum[27]) begin
      nm    = {sum[27:2], sum[1] | sum[0]};
      e     = 9'(ex) + 9'd1;
      field = e[7:0];
    end else begin
      sh    = (8'(lz) > ex - 8'd1) ? 5'(ex - 8'd1) : lz;
      nm    = sum[26:0] << sh;
      field = nm[26] ? (ex - 8'(sh)) : 8'd0;
    end
    mant_round: begin
      g   = nm[2];
      st  = nm[1] | nm[0];
      rnd = g & (st | nm[3]);
      mag = {field, nm[25:3]} + 31'(rnd);
    end
    r = {sx, mag};
    if (e > 9'd254) r = {sx, 8'hFF, 23'd0};
    if (sum == 28'd0) r = {a[31] & sb, 31'd0};
    if (a[30:23] == 8'hFF && a[22:0] == 23'd0) begin
      r = (b[30:23] == 8'hFF && b[22:0] == 23'd0 && a[31] == sb) ? a :
          ((b[30:23] == 8'hFF && b[22:0] == 23'd0) ? FpDefaultNan : a);
    end else if (b[30:23] == 8'hFF && b[22:0] == 23'd0) begin
      r = bn;
    end
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) r = b | 32'h0040_0000;
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) r = a | 32'h0040_0000;
    return r;
  endfunction

endpackage

// ----- rtl/fast_inverse_square_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Streaming reciprocal square root estimate with Newton-Raphson refinement.
// ----------------------------------------------------------------------------
// Accepts one single-precision bit pattern per cycle while s_axis_tready is
// high and returns one result per transaction, in order. Stage one halves the
// operand and forms the magic-constant guess; eight further stages run two
// refinements, one rounded float operation per stage (h*y, (h*y)*y, 1.5 -
// that, y times the correction).
// When refine_steps selects one refinement the second group carries the
// estimate through unchanged, so latency does not vary with the setting.
// The whole pipeline advances together: it moves whenever the output
// register is empty or being taken, so s_axis_tready drops only while a
// result waits. Write refine_steps only with the pipeline empty; 0 acts
// as 1 and 3 as 2.
module fast_inverse_square_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // refine_steps
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] operand_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata     // [31:0] recip_root_bits
);

  logic [1:0]      refine_steps_q;
  logic            en;
  logic            v0_q;
  fisr_pkg::item_t it0_q;
  fisr_pkg::item_t it0_d;
  logic            v1;
  fisr_pkg::item_t it1;
  logic            v2;
  fisr_pkg::item_t it2;

  // Advance every stage unless a finished result is stalled.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refine_steps_q <= 2'd1;
    end else if (cfg_we_i) begin
      refine_steps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  // Halve the operand and form the first guess.
  always_comb begin
    it0_d.h   = fisr_pkg::fp_mul(s_axis_tdata, fisr_pkg::FpHalf);
    it0_d.y   = fisr_pkg::GuessBase - {1'b0, s_axis_tdata[31:1]};
    it0_d.act = 1'b1;
    it0_d.two = refine_steps_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q <= it0_d;
    end
  end

  fisr_nr_step u_step1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .item_i  (it0_q),
    .valid_o (v1),
    .item_o  (it1)
  );

  fisr_nr_step u_step2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .item_i  (it1),
    .valid_o (v2),
    .item_o  (it2)
  );

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = it2.y;

endmodule

// ----- rtl/fisr_nr_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_nr_step
// One Newton-Raphson refinement in four register stages, one float op each.
// ----------------------------------------------------------------------------
module fisr_nr_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fisr_pkg::item_t item_i,
  output logic            valid_o,
  output fisr_pkg::item_t item_o
);

  logic [3:0]      v_q;
  fisr_pkg::item_t it1_q, it2_q, it3_q, it4_q;
  fisr_pkg::item_t it4_d;
  logic [31:0]     hy_q, hyy_q, corr_q;
  logic [31:0]     ny;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign ny = fisr_pkg::fp_mul(it3_q.y, corr_q);

  // Hold the estimate when this refinement is not requested.
  always_comb begin
    it4_d     = it3_q;
    it4_d.y   = it3_q.act ? ny : it3_q.y;
    it4_d.act = it3_q.two;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      hy_q   <= fisr_pkg::fp_mul(item_i.h, item_i.y);
      it2_q  <= it1_q;
      hyy_q  <= fisr_pkg::fp_mul(hy_q, it1_q.y);
      it3_q  <= it2_q;
      corr_q <= fisr_pkg::fp_sub(fisr_pkg::FpThreeHalves, hyy_q);
      it4_q  <= it4_d;
    end
  end

  assign valid_o = v_q[3];
  assign item_o  = it4_q;

endmodule

// ----- rtl/fisr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_checker
// Port-level checks on the stream handshake and pipeline flow.
// ----------------------------------------------------------------------------
`include "fast_inverse_square_root_assert.svh"
module fisr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `FISR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `FISR_ASSERT(a_in_ready, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input blocked with output free")
  `FISR_ASSERT(a_ready_stall, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while stalled")
  `FISR_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result shown after reset")

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/fast_inverse_square_root_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_tb
// Self-checking stream test of the reciprocal square root estimator.
// ----------------------------------------------------------------------------
// Drives operand transactions through several refine_steps settings: a short
// directed set of edge values, then random patterns biased towards normal
// positives with specials, subnormals and negatives mixed in. A local
// single-precision model predicts every result; results are checked in order.
// Both sides idle at random; one phase runs without idling, one holds the
// output off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_tb;

  localparam logic [31:0] MagicBase     = 32'h5F3504F3;
  localparam logic [31:0] SingleHalf    = 32'h3F000000;
  localparam logic [31:0] SingleOneHalf = 32'h3FC00000;
  localparam logic [31:0] QuietNan      = 32'hFFC00000;
  localparam int          DrainCycles   = 20;
  localparam int          StallLimit    = 3000;
  localparam int          HoldOffCycles = 300;

  // Reference estimator plus the queue of results still owed by the block.
  class recip_root_scoreboard;
    logic [1:0]  steps;
    logic [31:0] pending_roots[$];
    int          mismatches;

    function new();
      steps      = 2'd1;
      mismatches = 0;
    endfunction

    static function bit is_nan(logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    static function bit is_inf(logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] == 23'd0;
    endfunction

    static function real single_to_real(logic [31:0] v);
      real mag;
      if (v[30:23] == 8'hFF) return $bitstoreal({v[31], 11'h7FF, 52'd0});
      if (v[30:23] != 8'd0)
        return $bitstoreal({v[31], 11'(int'(v[30:23]) - 127 + 1023), v[22:0], 29'd0});
      if (v[22:0] == 23'd0) return $bitstoreal({v[31], 63'd0});
      // Subnormal: mantissa times 2^-149, exact in double.
      mag = real'(v[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
      return v[31] ? -mag : mag;
    endfunction

    // Round a double to single, nearest even, with gradual underflow.
    static function logic [31:0] real_to_single(real r);
      logic [63:0] d, m, q;
      int          fe, sh;
      bit          g, st, rnd;
      logic [30:0] mag;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      fe = int'(d[62:52]) - 1023 + 127;
      if (fe > 254) return {d[63], 8'hFF, 23'd0};
      m  = {11'd0, 1'b1, d[51:0]};
      sh = 29 + ((fe < 1) ? 1 - fe : 0);
      if (sh > 60) sh = 60;
      q   = m >> sh;
      g   = m[sh - 1];
      st  = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
      rnd = g & (st | q[0]);
      if (fe >= 1) mag = {fe[7:0], q[22:0]} + 31'(rnd);
      else mag = q[30:0] + 31'(rnd);
      return {d[63], mag};
    endfunction

    static function logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
      if (is_nan(a)) return a | 32'h0040_0000;
      if (is_nan(b)) return b | 32'h0040_0000;
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
        return QuietNan;
      return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    static function logic [31:0] single_sub(logic [31:0] a, logic [31:0] b);
      if (is_nan(a)) return a | 32'h0040_0000;
      if (is_nan(b)) return b | 32'h0040_0000;
      if (is_inf(a) && is_inf(b) && a[31] == b[31]) return QuietNan;
      return real_to_single(single_to_real(a) - single_to_real(b));
    endfunction

    static function logic [31:0] refine(logic [31:0] y, logic [31:0] h);
      logic [31:0] hy, hyy, corr;
      hy   = single_mul(h, y);
      hyy  = single_mul(hy, y);
      corr = single_sub(SingleOneHalf, hyy);
      return single_mul(y, corr);
    endfunction

    function logic [31:0] estimate_recip_root(logic [31:0] x);
      logic [31:0] h, y;
      h = single_mul(x, SingleHalf);
      y = MagicBase - (x >> 1);
      y = refine(y, h);
      // Zero saturates to one pass, three to two.
      if (steps >= 2'd2) y = refine(y, h);
      return y;
    endfunction

    function void note_operand(logic [31:0] x);
      pending_roots.push_back(estimate_recip_root(x));
    endfunction

    function void check_root(logic [31:0] actual);
      logic [31:0] want;
      if (pending_roots.size() == 0) begin
        $error("recip_root_bits: unexpected result %h", actual);
        mismatches++;
        return;
      end
      want = pending_roots.pop_front();
      if (want !== actual) begin
        $error("recip_root_bits: expected %h actual %h", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'd0;  // [31:0] operand_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] recip_root_bits

  recip_root_scoreboard board = new();
  bit quiet_phase = 1'b0;  // no idling on either side while set
  int hold_off    = 0;     // cycles the receiver still has to hold off
  int idle_count  = 0;

  fast_inverse_square_root u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: check each result transaction, then decide the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_root(m_axis_tdata);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_phase || ($urandom_range(99) >= 36);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Offer one operand, with random idle cycles first; hold until taken.
  task automatic send_operand(input logic [31:0] x);
    while (!quiet_phase && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    board.note_operand(x);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_roots.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_steps(input logic [1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.steps = v;
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1: ;
      2, 3, 4, 5: r[31:23] = {1'b0, 8'($urandom_range(1, 254))};
      6: r[30:23] = 8'd0;
      7: r[30:23] = 8'hFF;
      8: r[31:23] = {1'b1, 8'($urandom_range(1, 254))};
      default: r[30:23] = $urandom_range(1) ? 8'($urandom_range(1, 3))
                                            : 8'($urandom_range(252, 254));
    endcase
    // Pull a few operands onto the exact edge mantissas, zero or all ones.
    if ($urandom_range(19) == 0) r[22:0] = $urandom_range(1) ? 23'd0 : 23'h7FFFFF;
    return r;
  endfunction

  logic [31:0] edge_operands[20] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'h7F800001, 32'hFFFFFFFF, 32'h00000001, 32'h007FFFFF, 32'h00800000,
    32'h3F800000, 32'h40800000, 32'h7F7FFFFF, 32'hBF800000, 32'h3E800000,
    32'h5F3504F3, 32'hFFBFFFFF, 32'h80000001, 32'h3FFFFFFF, 32'h55555555
  };
  logic [1:0] step_plan[6] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (step_plan[p]) begin
      write_steps(step_plan[p]);
      if (p == 0 || p == 1) begin
        foreach (edge_operands[i]) send_operand(edge_operands[i]);
      end
      // Back-pressure: hold the output off while operands keep coming.
      if (p == 2) hold_off = HoldOffCycles;
      quiet_phase = (p == 4);
      for (int i = 0; i < 235; i++) begin
        // Pause the sender until the pipeline has fully drained once.
        if (p == 3 && i == 110) drain();
        send_operand(random_operand());
      end
      quiet_phase = 1'b0;
    end
    drain();
    if (board.mismatches == 0 && board.pending_roots.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
